// ===== hdl/assert_macros.svh =====
// ----------------------------------------------------------------------------
// assert_macros
// Assertion macros used by htsed_run of the tag stripper; ASSERT_OFF removes them.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF

`define ASSERT_IMPLIES(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("%m: same-cycle check failed");

`define ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("%m: next-cycle check failed");

`else

`define ASSERT_IMPLIES(label, clk, rst, ante, cons)

`define ASSERT_NEXT(label, clk, rst, ante, cons)

`endif

`endif

// ===== hdl/htsed_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// htsed_pkg
// Types, character codes and the UTF-8 encoder of the tag stripper.
// ----------------------------------------------------------------------------
package htsed_pkg;

   localparam int RUN_MAX = 7;
   localparam int CNT_W   = 3;

   localparam logic [7:0] CHR_NUL  = 8'h00;
   localparam logic [7:0] CHR_TAB  = 8'h09;
   localparam logic [7:0] CHR_LF   = 8'h0A;
   localparam logic [7:0] CHR_CR   = 8'h0D;
   localparam logic [7:0] CHR_SP   = 8'h20;
   localparam logic [7:0] CHR_HASH = 8'h23;
   localparam logic [7:0] CHR_AMP  = 8'h26;
   localparam logic [7:0] CHR_SL   = 8'h2F;
   localparam logic [7:0] CHR_0    = 8'h30;
   localparam logic [7:0] CHR_9    = 8'h39;
   localparam logic [7:0] CHR_SEMI = 8'h3B;
   localparam logic [7:0] CHR_LT   = 8'h3C;
   localparam logic [7:0] CHR_GT   = 8'h3E;
   localparam logic [7:0] CHR_B    = 8'h62;
   localparam logic [7:0] CHR_P    = 8'h70;
   localparam logic [7:0] CHR_R    = 8'h72;

   localparam logic [21:0] UTF8_MAX1 = 22'h00007F;
   localparam logic [21:0] UTF8_MAX2 = 22'h0007FF;
   localparam logic [21:0] UTF8_MAX3 = 22'h00FFFF;
   localparam logic [21:0] UTF8_MAX4 = 22'h1FFFFF;
   localparam logic [21:0] ENT_SAT   = 22'h3FFFFF;
   localparam logic [7:0]  UTF8_LEAD2 = 8'hC0;
   localparam logic [7:0]  UTF8_LEAD3 = 8'hE0;
   localparam logic [7:0]  UTF8_LEAD4 = 8'hF0;
   localparam logic [7:0]  UTF8_CONT  = 8'h80;
   localparam logic [5:0]  UTF8_MASK  = 6'h3F;

   localparam logic [1:0] CSR_DECODE   = 2'd0;
   localparam logic [1:0] CSR_PARA     = 2'd1;
   localparam logic [1:0] CSR_PARA_DBL = 2'd2;
   localparam logic [1:0] CSR_KEEP_NL  = 2'd3;

   typedef enum logic [2:0] {
      TAG_IDLE = 3'd0,
      TAG_OPEN = 3'd1,
      TAG_B    = 3'd2,
      TAG_BR   = 3'd3,
      TAG_P    = 3'd4
   } tag_stage_type;

   typedef struct packed {
      logic [7:0] in_byte;
      logic       end_of_text;
   } req_type;

   typedef struct packed {
      logic [7:0] out_byte;
      logic       byte_valid;
      logic       text_done;
      logic       run_last;
   } rsp_type;

   typedef struct packed {
      logic decode_entities;
      logic paragraph_breaks;
      logic paragraph_double;
      logic keep_newlines;
   } cfg_type;

   typedef struct packed {
      logic [7:0] out_byte;
      logic       byte_valid;
      logic       text_done;
   } res_type;

   typedef struct packed {
      res_type [RUN_MAX-1:0] entry;
      logic [CNT_W-1:0]      count;
   } run_type;

   typedef struct packed {
      logic [3:0][7:0] bytes;
      logic [2:0]      len;
   } frag_type;

   function automatic frag_type utf8_frag(input logic [21:0] v);
      frag_type f;
      f = '0;
      if (v == '0) begin
         f.len = 3'd0;
      end else if (v <= UTF8_MAX1) begin
         if (v[7:0] != CHR_CR && v[7:0] != CHR_LF) begin
            f.bytes[0] = v[7:0];
            f.len      = 3'd1;
         end
      end else if (v <= UTF8_MAX2) begin
         f.bytes[0] = UTF8_LEAD2 | {3'b0, v[10:6]};
         f.bytes[1] = UTF8_CONT | {2'b0, v[5:0] & UTF8_MASK};
         f.len      = 3'd2;
      end else if (v <= UTF8_MAX3) begin
         f.bytes[0] = UTF8_LEAD3 | {4'b0, v[15:12]};
         f.bytes[1] = UTF8_CONT | {2'b0, v[11:6] & UTF8_MASK};
         f.bytes[2] = UTF8_CONT | {2'b0, v[5:0] & UTF8_MASK};
         f.len      = 3'd3;
      end else if (v <= UTF8_MAX4) begin
         f.bytes[0] = UTF8_LEAD4 | {5'b0, v[20:18]};
         f.bytes[1] = UTF8_CONT | {2'b0, v[17:12] & UTF8_MASK};
         f.bytes[2] = UTF8_CONT | {2'b0, v[11:6] & UTF8_MASK};
         f.bytes[3] = UTF8_CONT | {2'b0, v[5:0] & UTF8_MASK};
         f.len      = 3'd4;
      end
      return f;
   endfunction

   function automatic frag_type flush_frag(input logic amp, input logic ent,
                                           input logic [21:0] v);
      frag_type f;
      f = '0;
      if (amp) begin
         f.bytes[0] = CHR_AMP;
         f.len      = 3'd1;
      end else if (ent) begin
         f = utf8_frag(v);
      end
      return f;
   endfunction

endpackage

// ===== hdl/htsed_csr.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// htsed_csr
// Control register file behind the APB-style port.
// ----------------------------------------------------------------------------
module htsed_csr (
   input  logic              clock,
   input  logic              reset,
   input  logic              csr_psel,
   input  logic              csr_penable,
   input  logic              csr_pwrite,
   input  logic [3:0]        csr_paddr,
   input  logic [31:0]       csr_pwdata,
   output logic [31:0]       csr_prdata,
   output logic              csr_pready,
   output htsed_pkg::cfg_type cfg
);
   import htsed_pkg::*;

   cfg_type cfg_ff;
   cfg_type cfg_in;
   logic    wr_en;

   assign csr_pready = 1'b1;
   assign wr_en      = csr_psel & csr_penable & csr_pwrite & csr_pready;

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         case (csr_paddr[3:2])
            CSR_DECODE:   cfg_in.decode_entities  = csr_pwdata[0];
            CSR_PARA:     cfg_in.paragraph_breaks = csr_pwdata[0];
            CSR_PARA_DBL: cfg_in.paragraph_double = csr_pwdata[0];
            CSR_KEEP_NL:  cfg_in.keep_newlines    = csr_pwdata[0];
            default:      cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   always_comb begin
      case (csr_paddr[3:2])
         CSR_DECODE:   csr_prdata = {31'b0, cfg_ff.decode_entities};
         CSR_PARA:     csr_prdata = {31'b0, cfg_ff.paragraph_breaks};
         CSR_PARA_DBL: csr_prdata = {31'b0, cfg_ff.paragraph_double};
         CSR_KEEP_NL:  csr_prdata = {31'b0, cfg_ff.keep_newlines};
         default:      csr_prdata = '0;
      endcase
   end

   assign cfg = cfg_ff;

endmodule

// ===== hdl/htsed_parse.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// htsed_parse
// Tag, newline and character-reference state; builds the result run of
// one input byte in a single pass.
// ----------------------------------------------------------------------------
module htsed_parse (
   input  logic               clock,
   input  logic               reset,
   input  logic               accept,
   input  htsed_pkg::req_type req,
   input  htsed_pkg::cfg_type cfg,
   output htsed_pkg::run_type run
);
   import htsed_pkg::*;

   logic          inside_ff, inside_in;
   tag_stage_type stage_ff, stage_in;
   logic          amp_ff, amp_in;
   logic          ent_ff, ent_in;
   logic [21:0]   val_ff, val_in;
   logic          acr_ff, acr_in;

   logic [7:0]    b;
   logic          is_digit;
   logic [25:0]   val_acc;
   logic          flush_pre;
   logic          flush_post;
   logic          done_main;
   logic          done;
   frag_type      frag_b;
   frag_type      frag_f;
   frag_type      first;
   frag_type      second;
   logic [3:0]    total;

   assign b        = req.in_byte;
   assign is_digit = (b >= CHR_0) && (b <= CHR_9);
   assign val_acc  = {1'b0, val_ff, 3'b0} + {3'b0, val_ff, 1'b0} + {22'b0, b[3:0]};

   always_comb begin
      inside_in = inside_ff;
      stage_in  = stage_ff;
      amp_in    = amp_ff;
      ent_in    = ent_ff;
      val_in    = val_ff;
      acr_in    = acr_ff;
      flush_pre = 1'b0;
      done_main = 1'b0;
      frag_b    = '0;
      if (b == CHR_NUL) begin
         flush_pre = 1'b1;
         done_main = 1'b1;
      end else if (b == CHR_LT) begin
         flush_pre = 1'b1;
         inside_in = 1'b1;
         stage_in  = TAG_OPEN;
         acr_in    = 1'b0;
      end else if (inside_ff) begin
         stage_in = TAG_IDLE;
         acr_in   = 1'b0;
         case (stage_ff)
            TAG_OPEN: begin
               if (b == CHR_B) begin
                  stage_in = TAG_B;
               end else if (b == CHR_P && cfg.paragraph_breaks) begin
                  stage_in = TAG_P;
               end
            end
            TAG_B: begin
               if (b == CHR_R) begin
                  stage_in = TAG_BR;
               end
            end
            TAG_BR: begin
               if (b == CHR_GT || b == CHR_SL || b == CHR_SP) begin
                  frag_b.bytes[0] = CHR_CR;
                  frag_b.bytes[1] = CHR_LF;
                  frag_b.len      = 3'd2;
               end
            end
            TAG_P: begin
               if (b == CHR_GT || b == CHR_SP) begin
                  frag_b.bytes[0] = CHR_CR;
                  frag_b.bytes[1] = CHR_LF;
                  frag_b.bytes[2] = CHR_CR;
                  frag_b.bytes[3] = CHR_LF;
                  frag_b.len      = cfg.paragraph_double ? 3'd4 : 3'd2;
               end
            end
            default: stage_in = TAG_IDLE;
         endcase
         if (b == CHR_GT) begin
            inside_in = 1'b0;
         end
      end else if (acr_ff && b == CHR_LF) begin
         acr_in = 1'b0;
      end else begin
         acr_in = 1'b0;
         if (b == CHR_CR || b == CHR_LF) begin
            flush_pre = 1'b1;
            if (cfg.keep_newlines) begin
               frag_b.bytes[0] = CHR_CR;
               frag_b.bytes[1] = CHR_LF;
               frag_b.len      = 3'd2;
            end
            acr_in = (b == CHR_CR);
         end else if (b == CHR_TAB || b == CHR_GT) begin
            acr_in = 1'b0;
         end else if (ent_ff) begin
            if (is_digit) begin
               val_in = (val_acc > {4'b0, ENT_SAT}) ? ENT_SAT : val_acc[21:0];
            end else if (b == CHR_SEMI) begin
               flush_pre = 1'b1;
            end
         end else if (amp_ff) begin
            if (b == CHR_HASH) begin
               amp_in = 1'b0;
               ent_in = 1'b1;
               val_in = '0;
            end else begin
               amp_in          = 1'b0;
               frag_b.bytes[0] = CHR_AMP;
               frag_b.len      = 3'd1;
               if (cfg.decode_entities && b == CHR_AMP) begin
                  amp_in = 1'b1;
               end else begin
                  frag_b.bytes[1] = b;
                  frag_b.len      = 3'd2;
               end
            end
         end else begin
            if (cfg.decode_entities && b == CHR_AMP) begin
               amp_in = 1'b1;
            end else begin
               frag_b.bytes[0] = b;
               frag_b.len      = 3'd1;
            end
         end
      end
      if (flush_pre) begin
         amp_in = 1'b0;
         ent_in = 1'b0;
         val_in = '0;
      end
      flush_post = req.end_of_text && !done_main;
      done       = done_main || req.end_of_text;
      if (flush_pre) begin
         frag_f = flush_frag(amp_ff, ent_ff, val_ff);
      end else if (flush_post) begin
         frag_f = flush_frag(amp_in, ent_in, val_in);
      end else begin
         frag_f = '0;
      end
      if (done) begin
         inside_in = 1'b0;
         stage_in  = TAG_IDLE;
         amp_in    = 1'b0;
         ent_in    = 1'b0;
         val_in    = '0;
         acr_in    = 1'b0;
      end
   end

   always_comb begin
      if (flush_pre) begin
         first  = frag_f;
         second = frag_b;
      end else begin
         first  = frag_b;
         second = frag_f;
      end
      total     = {1'b0, first.len} + {1'b0, second.len} + {3'b0, done};
      run.count = total[CNT_W-1:0];
      for (int i = 0; i < RUN_MAX; i++) begin
         logic [2:0] slot;
         logic [2:0] off;
         slot = 3'(i);
         off  = slot - first.len;
         if (slot < first.len) begin
            run.entry[i] = '{out_byte: first.bytes[slot[1:0]], byte_valid: 1'b1,
                             text_done: 1'b0};
         end else if (off < second.len) begin
            run.entry[i] = '{out_byte: second.bytes[off[1:0]], byte_valid: 1'b1,
                             text_done: 1'b0};
         end else begin
            run.entry[i] = '{out_byte: CHR_NUL, byte_valid: 1'b0, text_done: 1'b1};
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         inside_ff <= 1'b0;
         stage_ff  <= TAG_IDLE;
         amp_ff    <= 1'b0;
         ent_ff    <= 1'b0;
         val_ff    <= '0;
         acr_ff    <= 1'b0;
      end else if (accept) begin
         inside_ff <= inside_in;
         stage_ff  <= stage_in;
         amp_ff    <= amp_in;
         ent_ff    <= ent_in;
         val_ff    <= val_in;
         acr_ff    <= acr_in;
      end
   end

endmodule

// ===== hdl/htsed_run.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// htsed_run
// Result register: holds the run of one byte and hands it out one
// transfer per cycle while rsp_stall is low.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module htsed_run (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_xfer,
   input  htsed_pkg::run_type run,
   output logic               free,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output htsed_pkg::rsp_type rsp_data
);
   import htsed_pkg::*;

   res_type [RUN_MAX-1:0] entry_ff, entry_in;
   logic [CNT_W-1:0]      cnt_ff, cnt_in;
   logic [CNT_W-1:0]      idx_ff, idx_in;
   logic                  busy_ff, busy_in;
   logic                  last;
   logic                  rsp_xfer;
   logic                  load;
   res_type               cur;

   assign cur       = entry_ff[idx_ff];
   assign last      = (idx_ff == cnt_ff - CNT_W'(1));
   assign rsp_valid = busy_ff;
   assign rsp_xfer  = busy_ff & ~rsp_stall;
   assign free      = ~busy_ff | (rsp_xfer & last);
   assign load      = req_xfer & (run.count != '0);
   assign rsp_data  = '{out_byte: cur.out_byte, byte_valid: cur.byte_valid,
                        text_done: cur.text_done, run_last: last};

   always_comb begin
      entry_in = entry_ff;
      cnt_in   = cnt_ff;
      idx_in   = idx_ff;
      busy_in  = busy_ff;
      if (load) begin
         entry_in = run.entry;
         cnt_in   = run.count;
         idx_in   = '0;
         busy_in  = 1'b1;
      end else if (rsp_xfer) begin
         if (last) begin
            busy_in = 1'b0;
         end else begin
            idx_in = idx_ff + CNT_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff  <= '0;
         idx_ff  <= '0;
         busy_ff <= 1'b0;
      end else begin
         cnt_ff  <= cnt_in;
         idx_ff  <= idx_in;
         busy_ff <= busy_in;
      end
   end

   `ASSERT_IMPLIES(a_idx_in_run, clock, reset, busy_ff, idx_ff < cnt_ff)
   `ASSERT_IMPLIES(a_count_nonzero, clock, reset, busy_ff, cnt_ff != '0)
   `ASSERT_IMPLIES(a_marker_last, clock, reset, busy_ff && cur.text_done, last)
   `ASSERT_NEXT(a_run_drains, clock, reset, rsp_xfer && last && !load, !busy_ff)

endmodule

// ===== hdl/html_tag_strip_entity_decode.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// html_tag_strip_entity_decode
// HTML markup stripper with decimal character-reference to UTF-8 decoding.
// ----------------------------------------------------------------------------
// Each accepted byte is decoded in one pass into a run of zero to seven
// results, which is loaded into a result register and shown from the next
// cycle, one transfer per cycle unless rsp_stall. A byte with at most one
// result is taken every cycle unless rsp_stall; a byte with more results
// holds req_stall until its last result leaves. A byte with no result only
// updates the tag and reference state. Control registers at byte addresses 0, 4,
// 8 and 12 must be written by the user while the stream is idle, unenforced.
module html_tag_strip_entity_decode (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  htsed_pkg::req_type req_data,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output htsed_pkg::rsp_type rsp_data,
   input  logic               csr_psel,
   input  logic               csr_penable,
   input  logic               csr_pwrite,
   input  logic [3:0]         csr_paddr,
   input  logic [31:0]        csr_pwdata,
   output logic [31:0]        csr_prdata,
   output logic               csr_pready
);
   import htsed_pkg::*;

   cfg_type cfg;
   run_type run;
   logic    free;
   logic    req_xfer;

   assign req_stall = ~free;
   assign req_xfer  = req_valid & free;

   htsed_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   htsed_parse u_parse (
      .clock  (clock),
      .reset  (reset),
      .accept (req_xfer),
      .req    (req_data),
      .cfg    (cfg),
      .run    (run)
   );

   htsed_run u_run (
      .clock     (clock),
      .reset     (reset),
      .req_xfer  (req_xfer),
      .run       (run),
      .free      (free),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

endmodule
